FILE: hw/rtl/mmf_pkg.sv
package mmf_pkg;

   localparam int MAX_DIM = 32;
   localparam int DIM_W   = 6;
   localparam int IDX_W   = 5;
   localparam int VALUE_W = 32;
   localparam int DIV_W   = 16;
   localparam int MODE_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [MODE_W-1:0] MODE_ALL     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CORNERS = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BORDER  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIAG    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PRIME   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_MODE = 2'd2;

   typedef struct packed {
      logic load;
      logic emit_mask;
      logic prime_init;
      logic div_start;
      logic next_divisor;
      logic emit_prime;
      logic emit_zero;
   } mmf_cmd_type;

   typedef struct packed {
      logic need_prime;
      logic sq_over;
      logic rem_done;
      logic rem_zero;
   } mmf_status_type;

endpackage

FILE: hw/rtl/mmf_rem.sv
module mmf_rem
   import mmf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-2:0] dividend,
   input  logic [DIV_W-1:0]   divisor,
   output logic               done,
   output logic               rem_zero
);

   localparam int CNT_W = $clog2(VALUE_W - 1);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [VALUE_W-2:0] shreg_ff, shreg_in;
   logic [DIV_W:0]     trial;

   // one quotient bit per cycle, restoring form, remainder only
   assign trial = {rem_ff, shreg_ff[VALUE_W-2]};

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shreg_in = shreg_ff;
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = CNT_W'(VALUE_W - 2);
         rem_in   = '0;
         shreg_in = dividend;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIV_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         shreg_in = {shreg_ff[VALUE_W-3:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      shreg_ff <= shreg_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

FILE: hw/rtl/mmf_dpath.sv
module mmf_dpath
   import mmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  mmf_cmd_type          cmd,
   output mmf_status_type       status,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic [VALUE_W-1:0]   req_element_value,
   input  logic [IDX_W-1:0]     req_row_index,
   input  logic [IDX_W-1:0]     req_col_index,
   output logic                 rsp_strobe,
   output logic [VALUE_W-1:0]   rsp_shown_value,
   output logic                 rsp_shape_error
);

   logic [DIM_W-1:0]   row_count_ff;
   logic [DIM_W-1:0]   col_count_ff;
   logic [MODE_W-1:0]  mask_mode_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [IDX_W-1:0]   row_ff;
   logic [IDX_W-1:0]   col_ff;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [VALUE_W-1:0] div_sq_ff, div_sq_in;
   logic               strobe_ff;
   logic [VALUE_W-1:0] shown_ff, shown_in;
   logic               err_ff, err_in;

   logic [DIM_W-1:0] rows_eff, cols_eff, i6, j6;
   logic             in_matrix, rim_row, rim_col, on_diag;
   logic             sel, err;
   logic             need_prime, sq_over, rem_done, rem_zero;

   function automatic logic [DIM_W-1:0] clamp_count(input logic [DIM_W-1:0] c);
      logic [DIM_W-1:0] r;
      r = c;
      if (c == '0) begin
         r = DIM_W'(1);
      end else if (c > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_W'(1);
         col_count_ff <= DIM_W'(1);
         mask_mode_ff <= MODE_ALL;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROW_COUNT: row_count_ff <= csr_wdata;
            REG_COL_COUNT: col_count_ff <= csr_wdata;
            REG_MASK_MODE: mask_mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff <= req_element_value;
         row_ff <= req_row_index;
         col_ff <= req_col_index;
      end
   end

   assign rows_eff  = clamp_count(row_count_ff);
   assign cols_eff  = clamp_count(col_count_ff);
   assign i6        = {1'b0, row_ff};
   assign j6        = {1'b0, col_ff};
   assign in_matrix = (i6 < rows_eff) && (j6 < cols_eff);
   assign rim_row   = (i6 == '0) || (i6 == rows_eff - DIM_W'(1));
   assign rim_col   = (j6 == '0) || (j6 == cols_eff - DIM_W'(1));
   assign on_diag   = (i6 == j6) || (DIM_W'(i6 + j6) == cols_eff - DIM_W'(1));

   always_comb begin
      sel = 1'b0;
      err = 1'b0;
      case (mask_mode_ff)
         MODE_ALL:     sel = in_matrix;
         MODE_CORNERS: sel = in_matrix && rim_row && rim_col;
         MODE_BORDER:  sel = in_matrix && (rim_row || rim_col);
         MODE_DIAG: begin
            if (rows_eff != cols_eff) begin
               err = 1'b1;
            end else begin
               sel = in_matrix && on_diag;
            end
         end
         default: sel = 1'b0;
      endcase
   end

   // trial divisor and its square, square advanced by 2d+1
   always_comb begin
      div_in    = div_ff;
      div_sq_in = div_sq_ff;
      if (cmd.prime_init) begin
         div_in    = DIV_W'(2);
         div_sq_in = VALUE_W'(4);
      end else if (cmd.next_divisor) begin
         div_in    = div_ff + 1'b1;
         div_sq_in = div_sq_ff + VALUE_W'({div_ff, 1'b1});
      end
   end

   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      div_sq_ff <= div_sq_in;
   end

   mmf_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (val_ff[VALUE_W-2:0]),
      .divisor  (div_ff),
      .done     (rem_done),
      .rem_zero (rem_zero)
   );

   assign need_prime = (mask_mode_ff == MODE_PRIME) && in_matrix
                       && !val_ff[VALUE_W-1] && (val_ff[VALUE_W-2:1] != '0);
   assign sq_over    = div_sq_ff > {1'b0, val_ff[VALUE_W-2:0]};
   assign status     = {need_prime, sq_over, rem_done, rem_zero};

   always_comb begin
      shown_in = '0;
      err_in   = 1'b0;
      if (cmd.emit_mask) begin
         shown_in = sel ? val_ff : '0;
         err_in   = err;
      end else if (cmd.emit_prime) begin
         shown_in = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_mask || cmd.emit_prime || cmd.emit_zero;
      end
      shown_ff <= shown_in;
      err_ff   <= err_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_shown_value = shown_ff;
   assign rsp_shape_error = err_ff;

endmodule

FILE: hw/rtl/mmf_ctrl.sv
module mmf_ctrl
   import mmf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  mmf_status_type status,
   output mmf_cmd_type    cmd,
   output logic           busy
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_TEST   = 2'd2;
   localparam logic [1:0] S_DIVIDE = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.need_prime) begin
               cmd.prime_init = 1'b1;
               state_in       = S_TEST;
            end else begin
               cmd.emit_mask = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_TEST: begin
            if (status.sq_over) begin
               cmd.emit_prime = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (status.rem_done) begin
               if (status.rem_zero) begin
                  cmd.emit_zero = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.next_divisor = 1'b1;
                  state_in         = S_TEST;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: hw/rtl/matrix_element_mask_filter.sv
// Outside prime mode the item is registered on accept, the decide state
// issues the mask command and the strobe register shows the result beat.
// Prime mode adds, per trial divisor, a test state and the 31-step remainder
// unit with its done beat. Throughput: one item at a time; busy drops in the
// cycle the result shows, so a large prime near 2^31 holds the block longest.
// Reset (sync, active high) clears FSM, strobe, config; receiver cannot stall.
module matrix_element_mask_filter
   import mmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [VALUE_W-1:0]   req_element_value,
   input  logic [IDX_W-1:0]     req_row_index,
   input  logic [IDX_W-1:0]     req_col_index,
   output logic                 rsp_strobe,
   output logic [VALUE_W-1:0]   rsp_shown_value,
   output logic                 rsp_shape_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   mmf_cmd_type    cmd;
   mmf_status_type status;

   // config writes are registered directly, so the port never pushes back
   assign csr_ready = 1'b1;

   // sequencer: owns the item flow, drives the datapath by commands only
   mmf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // datapath: config regs, mask decode, trial divisor and output beat
   mmf_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_element_value (req_element_value),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_shown_value   (rsp_shown_value),
      .rsp_shape_error   (rsp_shape_error)
   );

   // an accepted beat always makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // a result beat only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a preceding busy cycle");

   // a shape error never carries a value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_shape_error) |-> (rsp_shown_value == '0))
      else $error("shape error with nonzero shown value");

   // at most one emit command at a time, and never while idle
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.emit_mask, cmd.emit_prime, cmd.emit_zero}) <= 1
      && !(!busy && (cmd.emit_mask || cmd.emit_prime || cmd.emit_zero)))
      else $error("conflicting or idle emit command");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench
   import mmf_pkg::*;
();

   // Run length and watchdog. Prime mode dominates the cycle budget: each trial
   // divisor runs the full remainder unit, so prime-mode values stay small or cheap.
   localparam int unsigned RANDOM_ITEMS = 555;
   localparam int unsigned QUIET_TAIL   = 80;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 20_000_000;
   localparam int unsigned MAX_REPORTS  = 10;

   localparam bit CHECK_MODEL = 1'b0;
   localparam bit CHECK_FIXED = 1'b1;

   typedef struct packed {
      logic [VALUE_W-1:0] shown_value;
      logic               shape_error;
   } mask_result_type;

   // One row of the directed sweep: the register settings it runs under, the
   // element beat, and an optional hand-typed result.
   typedef struct packed {
      logic [DIM_W-1:0]   rows;
      logic [DIM_W-1:0]   cols;
      logic [DIM_W-1:0]   mode;
      logic [VALUE_W-1:0] value;
      logic [IDX_W-1:0]   ri;
      logic [IDX_W-1:0]   ci;
      logic               check;
      logic [VALUE_W-1:0] exp_shown;
      logic               exp_error;
   } probe_type;

   localparam int NUM_PROBES = 26;

   localparam probe_type PROBES [NUM_PROBES] = '{
      // reset settings: 1x1 matrix, show all
      '{6'd1, 6'd1, 6'(MODE_ALL), 32'h7FFF_FFFF, 5'd0, 5'd0,
        CHECK_FIXED, 32'h7FFF_FFFF, 1'b0},
      '{6'd1, 6'd1, 6'(MODE_ALL), 32'h8000_0000, 5'd0, 5'd1,
        CHECK_FIXED, 32'h0, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_ALL), 32'hFFFF_FFFF, 5'd31, 5'd31,
        CHECK_FIXED, 32'hFFFF_FFFF, 1'b0},
      // zero counts act as one
      '{6'd0, 6'd0, 6'(MODE_ALL), 32'h1234_5678, 5'd0, 5'd0,
        CHECK_FIXED, 32'h1234_5678, 1'b0},
      '{6'd0, 6'd0, 6'(MODE_ALL), 32'h1234_5678, 5'd1, 5'd0,
        CHECK_FIXED, 32'h0, 1'b0},
      // counts above the limit act as the limit
      '{6'd63, 6'd63, 6'(MODE_ALL), 32'h5A5A_5A5A, 5'd31, 5'd31,
        CHECK_FIXED, 32'h5A5A_5A5A, 1'b0},
      '{6'd5, 6'd7, 6'(MODE_CORNERS), 32'd11, 5'd4, 5'd6, CHECK_MODEL, 32'h0, 1'b0},
      '{6'd5, 6'd7, 6'(MODE_CORNERS), 32'd11, 5'd4, 5'd3, CHECK_MODEL, 32'h0, 1'b0},
      '{6'd5, 6'd7, 6'(MODE_BORDER), 32'd13, 5'd2, 5'd6, CHECK_MODEL, 32'h0, 1'b0},
      '{6'd5, 6'd7, 6'(MODE_BORDER), 32'd13, 5'd2, 5'd3, CHECK_MODEL, 32'h0, 1'b0},
      '{6'd6, 6'd6, 6'(MODE_DIAG), 32'd17, 5'd2, 5'd3, CHECK_MODEL, 32'h0, 1'b0},
      '{6'd6, 6'd6, 6'(MODE_DIAG), 32'd17, 5'd4, 5'd4, CHECK_MODEL, 32'h0, 1'b0},
      '{6'd6, 6'd6, 6'(MODE_DIAG), 32'd17, 5'd1, 5'd3, CHECK_MODEL, 32'h0, 1'b0},
      // diagonals on a non-square matrix: shape error on every element
      '{6'd6, 6'd7, 6'(MODE_DIAG), 32'd99, 5'd0, 5'd0, CHECK_FIXED, 32'h0, 1'b1},
      '{6'd6, 6'd7, 6'(MODE_DIAG), 32'd99, 5'd31, 5'd31, CHECK_FIXED, 32'h0, 1'b1},
      // primes: smallest prime, values below two, negative, 16-bit and
      // 20-bit primes, composites
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'd2, 5'd0, 5'd0, CHECK_FIXED, 32'd2, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'd1, 5'd0, 5'd0, CHECK_FIXED, 32'h0, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'd0, 5'd0, 5'd0, CHECK_FIXED, 32'h0, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'hFFFF_FFFD, 5'd0, 5'd0,
        CHECK_FIXED, 32'h0, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'd65521, 5'd5, 5'd9,
        CHECK_FIXED, 32'd65521, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'd1000003, 5'd9, 5'd5,
        CHECK_FIXED, 32'd1000003, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'd1000001, 5'd1, 5'd1,
        CHECK_FIXED, 32'h0, 1'b0},
      '{6'd32, 6'd32, 6'(MODE_PRIME), 32'h7FFF_FFFE, 5'd1, 5'd1,
        CHECK_FIXED, 32'h0, 1'b0},
      // unused modes, upper data bits set and ignored by the 3-bit register
      '{6'h3D, 6'd32, 6'h3D, 32'd1, 5'd0, 5'd0, CHECK_FIXED, 32'h0, 1'b0},
      '{6'h3F, 6'd32, 6'h3F, 32'hFFFF_FFFF, 5'd0, 5'd0, CHECK_FIXED, 32'h0, 1'b0},
      // prime element outside the matrix
      '{6'd3, 6'd3, 6'(MODE_PRIME), 32'd7, 5'd3, 5'd0, CHECK_FIXED, 32'h0, 1'b0}
   };

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [VALUE_W-1:0]   req_element_value = '0;
   logic [IDX_W-1:0]     req_row_index = '0;
   logic [IDX_W-1:0]     req_col_index = '0;
   logic                 rsp_strobe;
   logic [VALUE_W-1:0]   rsp_shown_value;
   logic                 rsp_shape_error;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   // Shadow copy of the register file, as written (unclamped).
   logic [DIM_W-1:0]  cfg_rows = 6'd1;
   logic [DIM_W-1:0]  cfg_cols = 6'd1;
   logic [MODE_W-1:0] cfg_mode = MODE_ALL;

   mask_result_type pending_results[$];
   int unsigned     fail_count = 0;
   int unsigned     cycle_count = 0;

   matrix_element_mask_filter dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element_value (req_element_value),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_shown_value   (rsp_shown_value),
      .rsp_shape_error   (rsp_shape_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clamp a count register to the range the block actually uses.
   function automatic int eff_dim(logic [DIM_W-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_DIM) return MAX_DIM;
      return int'(count);
   endfunction

   // Trial division; stop once the divisor squared passes the value.
   function automatic bit value_is_prime(logic [VALUE_W-1:0] v);
      longint n;
      longint d;
      if (v[VALUE_W-1]) return 1'b0;
      n = longint'(v);
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Predict the masked element under the current shadow settings.
   function automatic mask_result_type filter_element(logic [VALUE_W-1:0] v,
                                                      logic [IDX_W-1:0] ri,
                                                      logic [IDX_W-1:0] ci);
      int              rows;
      int              cols;
      int              i;
      int              j;
      bit              in_bounds;
      bit              rim_row;
      bit              rim_col;
      bit              sel;
      mask_result_type res;
      rows      = eff_dim(cfg_rows);
      cols      = eff_dim(cfg_cols);
      i         = int'(ri);
      j         = int'(ci);
      in_bounds = (i < rows) && (j < cols);
      rim_row   = (i == 0) || (i == rows - 1);
      rim_col   = (j == 0) || (j == cols - 1);
      sel       = 1'b0;
      res.shape_error = 1'b0;
      case (cfg_mode)
         MODE_ALL:     sel = in_bounds;
         MODE_CORNERS: sel = in_bounds && rim_row && rim_col;
         MODE_BORDER:  sel = in_bounds && (rim_row || rim_col);
         MODE_DIAG: begin
            if (rows != cols) res.shape_error = 1'b1;
            else sel = in_bounds && ((i == j) || (i + j == cols - 1));
         end
         MODE_PRIME:   sel = in_bounds && value_is_prime(v);
         default:      sel = 1'b0;
      endcase
      res.shown_value = sel ? v : '0;
      return res;
   endfunction

   // Lower start and hold for a number of cycles.
   task automatic hold_off(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off new elements until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Drive one register write beat; csr_valid stays high for the caller.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ROW_COUNT: cfg_rows = data;
         REG_COL_COUNT: cfg_cols = data;
         REG_MASK_MODE: cfg_mode = data[MODE_W-1:0];
         default: ;
      endcase
   endtask

   // Reprogram all three registers with the block idle.
   task automatic apply_config(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                               logic [DIM_W-1:0] mode);
      drain_results();
      write_csr(REG_ROW_COUNT, rows);
      write_csr(REG_COL_COUNT, cols);
      write_csr(REG_MASK_MODE, mode);
      csr_valid <= 1'b0;
   endtask

   // Present one element beat and wait for the block to take it; start stays
   // high afterward so a following beat can go out back to back.
   task automatic send_element(logic [VALUE_W-1:0] v, logic [IDX_W-1:0] ri,
                               logic [IDX_W-1:0] ci, bit fixed,
                               mask_result_type fixed_res);
      start             <= 1'b1;
      req_element_value <= v;
      req_row_index     <= ri;
      req_col_index     <= ci;
      do @(posedge clock); while (busy);
      pending_results.push_back(fixed ? fixed_res : filter_element(v, ri, ci));
   endtask

   // Random idle burst, none during the quiet tail.
   task automatic maybe_idle(bit quiet);
      if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
   endtask

   // Mostly legal counts, with zero, the limit and over-range mixed in.
   function automatic logic [DIM_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 6'd0;
         1:       return 6'($urandom_range(MAX_DIM + 1, 63));
         2:       return 6'(MAX_DIM);
         3:       return 6'd1;
         default: return 6'($urandom_range(1, MAX_DIM));
      endcase
   endfunction

   // Favor the rim and the interior; leave some indexes anywhere in range.
   function automatic logic [IDX_W-1:0] pick_index(int dim);
      case ($urandom_range(0, 9))
         0, 1:    return IDX_W'($urandom_range(0, 31));
         2, 3:    return IDX_W'($urandom_range(0, 1) ? dim - 1 : 0);
         default: return IDX_W'($urandom_range(0, dim - 1));
      endcase
   endfunction

   // Values for prime mode stay cheap for the trial divider: small and 16-bit numbers,
   // negatives, and composites with a tiny factor.
   function automatic logic [VALUE_W-1:0] pick_prime_value();
      logic [VALUE_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return VALUE_W'($urandom_range(0, 4095));
         4, 5:       return {1'b1, raw[VALUE_W-2:0]};
         6, 7:       return {1'b0, raw[VALUE_W-2:1], 1'b0};
         8:          return VALUE_W'(3 * $urandom_range(1, 700_000_000));
         default:    return VALUE_W'($urandom_range(4096, 65535));
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Result checker: every strobe beat retires the oldest prediction.
   always @(posedge clock) begin
      mask_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected result: shown_value=%h shape_error=%b",
                        rsp_shown_value, rsp_shape_error);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_shown_value !== want.shown_value ||
                rsp_shape_error !== want.shape_error) begin
               if (fail_count < MAX_REPORTS)
                  $display("mismatch: shown_value exp %h got %h, shape_error exp %b got %b",
                           want.shown_value, rsp_shown_value,
                           want.shape_error, rsp_shape_error);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [DIM_W-1:0]   applied_rows;
      logic [DIM_W-1:0]   applied_cols;
      logic [DIM_W-1:0]   applied_mode;
      logic [DIM_W-1:0]   rows;
      logic [DIM_W-1:0]   cols;
      logic [DIM_W-1:0]   mode;
      logic [VALUE_W-1:0] v;
      int unsigned        sent;
      int unsigned        burst;
      mask_result_type    typed;

      applied_rows = 6'd1;
      applied_cols = 6'd1;
      applied_mode = 6'(MODE_ALL);
      sent         = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sweep; reprogram only where a row asks for new settings.
      for (int p = 0; p < NUM_PROBES; p++) begin
         if (PROBES[p].rows != applied_rows || PROBES[p].cols != applied_cols ||
             PROBES[p].mode != applied_mode) begin
            apply_config(PROBES[p].rows, PROBES[p].cols, PROBES[p].mode);
            applied_rows = PROBES[p].rows;
            applied_cols = PROBES[p].cols;
            applied_mode = PROBES[p].mode;
         end
         typed.shown_value = PROBES[p].exp_shown;
         typed.shape_error = PROBES[p].exp_error;
         send_element(PROBES[p].value, PROBES[p].ri, PROBES[p].ci,
                      PROBES[p].check, typed);
         maybe_idle(1'b0);
      end

      // Random phases: drain, pick new settings, then a burst of elements.
      // Each drain doubles as a full pause of the sender.
      typed = '0;
      while (sent < RANDOM_ITEMS) begin
         rows = pick_count();
         cols = $urandom_range(0, 1) ? rows : pick_count();
         mode[MODE_W-1:0]     = ($urandom_range(0, 9) < 9) ? MODE_W'($urandom_range(0, 4))
                                                           : MODE_W'($urandom_range(5, 7));
         mode[DIM_W-1:MODE_W] = ($urandom_range(0, 1) ? 3'($urandom) : 3'd0);
         apply_config(rows, cols, mode);
         burst = $urandom_range(8, 48);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            v = (cfg_mode == MODE_PRIME) ? pick_prime_value() : pick_value();
            send_element(v, pick_index(eff_dim(cfg_rows)),
                         pick_index(eff_dim(cfg_cols)), CHECK_MODEL, typed);
            sent++;
            maybe_idle(sent >= RANDOM_ITEMS - QUIET_TAIL);
         end
      end

      // Let the last results drain, then watch a little longer for strays.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
